@@ design/uhrc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uhrc_pkg
// Shared types, command codes and datapath operation codes for the undo
// history ring controller.
// ----------------------------------------------------------------------------
package uhrc_pkg;

  // width of a layer tag and of every slot field on the ports
  localparam int TAG_W      = 4;
  localparam int TAG_VALUES = 1 << TAG_W;

  // default sizing
  localparam int HISTORY_DEPTH_DEF = 16;
  localparam int LAYER_COUNT_DEF   = 16;

  // command codes
  localparam logic [1:0] CMD_ADD  = 2'd0;
  localparam logic [1:0] CMD_UNDO = 2'd1;
  localparam logic [1:0] CMD_REDO = 2'd2;

  // datapath operation codes
  localparam int OP_W = 4;
  localparam logic [OP_W-1:0] OP_IDLE       = 4'd0;
  localparam logic [OP_W-1:0] OP_LATCH      = 4'd1;
  localparam logic [OP_W-1:0] OP_ADD        = 4'd2;
  localparam logic [OP_W-1:0] OP_ADD_EVICT  = 4'd3;
  localparam logic [OP_W-1:0] OP_STATUS_ONE = 4'd4;
  localparam logic [OP_W-1:0] OP_UNDO_START = 4'd5;
  localparam logic [OP_W-1:0] OP_UNDO_TAG   = 4'd6;
  localparam logic [OP_W-1:0] OP_SCAN       = 4'd7;
  localparam logic [OP_W-1:0] OP_REDO       = 4'd8;
  localparam logic [OP_W-1:0] OP_REDO_TAG   = 4'd9;

  // input transaction
  typedef struct packed {
    logic [1:0]       cmd;
    logic [TAG_W-1:0] layer_id;
  } req_t;

  // result transaction
  typedef struct packed {
    logic             status;
    logic [TAG_W-1:0] slot;
    logic [TAG_W-1:0] target_layer;
    logic             use_base;
    logic             evicted;
    logic [TAG_W-1:0] evicted_slot;
    logic [TAG_W-1:0] evicted_layer;
  } res_t;

  // controller to datapath
  typedef struct packed {
    logic [OP_W-1:0] op;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] cmd;
    logic       empty;
    logic       full_next;
    logic       undo_base;
    logic       scan_done;
  } dp_status_t;

  // layer id reduction table, entry i holds i modulo count
  function automatic logic [TAG_VALUES*TAG_W-1:0] layer_mod_table(input int count);
    logic [TAG_VALUES*TAG_W-1:0] tbl;
    int r;
    tbl = '0;
    r = 0;
    for (int i = 0; i < TAG_VALUES; i++) begin
      tbl[i*TAG_W +: TAG_W] = r[TAG_W-1:0];
      r = r + 1;
      if (r >= count) begin
        r = 0;
      end
    end
    return tbl;
  endfunction

endpackage

@@ design/undo_history_ring_controller_top.sv @@
`timescale 1ns / 1ps
// throughput: one transaction at a time; the single tag store read port and
//   the backward search loop set the undo time; next start the cycle done shows
// reset: synchronous, pointers to zero and all tag valid bits cleared at once
// done strobes one cycle with result; the receiver cannot stall
// ----------------------------------------------------------------------------
// undo_history_ring_controller_top
// Slot bookkeeping for a circular undo history of layer snapshots: add,
// undo with backward same-layer search, and redo.
// ----------------------------------------------------------------------------
module undo_history_ring_controller_top
  import uhrc_pkg::*;
#(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
  parameter int LAYER_COUNT   = LAYER_COUNT_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t request,
  output logic done,
  output res_t result
);

  dp_cmd_t    ctl;
  dp_status_t sts;

  // controller
  uhrc_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .sts  (sts),
    .ctl  (ctl),
    .busy (busy),
    .done (done)
  );

  // datapath
  uhrc_datapath #(
    .HISTORY_DEPTH(HISTORY_DEPTH),
    .LAYER_COUNT  (LAYER_COUNT)
  ) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .request(request),
    .ctl    (ctl),
    .sts    (sts),
    .result (result)
  );

endmodule

@@ design/uhrc_tag_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uhrc_tag_mem
// Layer tag store, one write and one registered read per cycle. Per-entry
// valid bits make unwritten entries read as zero after reset.
// ----------------------------------------------------------------------------
module uhrc_tag_mem
  import uhrc_pkg::*;
#(
  parameter int DEPTH  = HISTORY_DEPTH_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [TAG_W-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [TAG_W-1:0]  rd_data
);

  logic [TAG_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0] valid;
  logic [TAG_W-1:0] rd_data_q;
  logic             rd_valid_q;

  // storage array
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  // valid bits, cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid_q <= valid[rd_addr];
      end
    end
  end

  // never-written entries read as zero
  assign rd_data = rd_valid_q ? rd_data_q : '0;

endmodule

@@ design/uhrc_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uhrc_datapath
// Ring pointers, search registers, tag store and result register. Executes
// one operation per cycle as chosen by the controller.
// ----------------------------------------------------------------------------
module uhrc_datapath
  import uhrc_pkg::*;
#(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
  parameter int LAYER_COUNT   = LAYER_COUNT_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  req_t       request,
  input  dp_cmd_t    ctl,
  output dp_status_t sts,
  output res_t       result
);

  localparam int PTR_W = $clog2(HISTORY_DEPTH);
  localparam logic [TAG_VALUES*TAG_W-1:0] MOD_TABLE = layer_mod_table(LAYER_COUNT);

  logic [PTR_W-1:0] oldest_ptr;
  logic [PTR_W-1:0] write_ptr;
  logic [PTR_W-1:0] scan_addr;
  logic [TAG_W-1:0] tag_q;
  logic [TAG_W-1:0] lay_q;
  logic [1:0]       cmd_q;
  res_t             res;
  res_t             res_next;

  logic [PTR_W-1:0] wp_next;
  logic [PTR_W-1:0] wp_prev;
  logic [PTR_W-1:0] old_next;
  logic [PTR_W-1:0] scan_prev;

  logic             mem_wr;
  logic             mem_rd;
  logic [PTR_W-1:0] mem_rd_addr;
  logic [TAG_W-1:0] mem_rd_data;

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(HISTORY_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PTR_W-1:0] ring_prev(input logic [PTR_W-1:0] p);
    return (p == '0) ? PTR_W'(HISTORY_DEPTH - 1) : p - 1'b1;
  endfunction

  // slot fields carry the low bits of a pointer
  function automatic logic [TAG_W-1:0] slot_of(input logic [PTR_W-1:0] p);
    logic [PTR_W+TAG_W-1:0] ext;
    ext = {{TAG_W{1'b0}}, p};
    return ext[TAG_W-1:0];
  endfunction

  // neighbor pointers
  assign wp_next   = ring_next(write_ptr);
  assign wp_prev   = ring_prev(write_ptr);
  assign old_next  = ring_next(oldest_ptr);
  assign scan_prev = ring_prev(scan_addr);

  // tag store port control
  always_comb begin
    mem_wr      = 1'b0;
    mem_rd      = 1'b0;
    mem_rd_addr = write_ptr;
    case (ctl.op)
      OP_ADD: begin
        mem_wr      = 1'b1;
        mem_rd      = (wp_next == oldest_ptr);
        mem_rd_addr = wp_next;
      end
      OP_UNDO_START, OP_UNDO_TAG: begin
        mem_rd      = 1'b1;
        mem_rd_addr = wp_prev;
      end
      OP_SCAN: begin
        mem_rd      = 1'b1;
        mem_rd_addr = scan_prev;
      end
      OP_REDO: begin
        mem_rd      = 1'b1;
        mem_rd_addr = write_ptr;
      end
      default: begin
        mem_rd = 1'b0;
      end
    endcase
  end

  uhrc_tag_mem #(
    .DEPTH (HISTORY_DEPTH),
    .ADDR_W(PTR_W)
  ) u_tag_mem (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (mem_wr),
    .wr_addr(write_ptr),
    .wr_data(lay_q),
    .rd_en  (mem_rd),
    .rd_addr(mem_rd_addr),
    .rd_data(mem_rd_data)
  );

  // status back to the controller
  assign sts.cmd       = cmd_q;
  assign sts.empty     = (write_ptr == oldest_ptr);
  assign sts.full_next = (wp_next == oldest_ptr);
  assign sts.undo_base = (write_ptr == oldest_ptr) || (wp_prev == oldest_ptr);
  assign sts.scan_done = (mem_rd_data == tag_q) || (scan_prev == oldest_ptr);

  // ring pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      oldest_ptr <= '0;
      write_ptr  <= '0;
    end else begin
      case (ctl.op)
        OP_ADD: begin
          write_ptr <= wp_next;
          if (wp_next == oldest_ptr) begin
            oldest_ptr <= old_next;
          end
        end
        OP_UNDO_START: write_ptr <= wp_prev;
        OP_REDO:       write_ptr <= wp_next;
        default: begin
          write_ptr <= write_ptr;
        end
      endcase
    end
  end

  // result register next value
  always_comb begin
    res_next = res;
    case (ctl.op)
      OP_ADD: begin
        res_next              = '0;
        res_next.slot         = slot_of(write_ptr);
        res_next.target_layer = lay_q;
        if (wp_next == oldest_ptr) begin
          res_next.evicted      = 1'b1;
          res_next.evicted_slot = slot_of(wp_next);
        end
      end
      OP_ADD_EVICT: res_next.evicted_layer = mem_rd_data;
      OP_STATUS_ONE: begin
        res_next        = '0;
        res_next.status = 1'b1;
      end
      OP_UNDO_START: res_next = '0;
      OP_UNDO_TAG: begin
        res_next.target_layer = mem_rd_data;
        if (sts.undo_base) begin
          res_next.use_base = 1'b1;
        end
      end
      OP_SCAN: begin
        if (mem_rd_data == tag_q) begin
          res_next.slot = slot_of(scan_addr);
        end else if (scan_prev == oldest_ptr) begin
          res_next.use_base = 1'b1;
        end
      end
      OP_REDO: begin
        res_next      = '0;
        res_next.slot = slot_of(write_ptr);
      end
      OP_REDO_TAG: res_next.target_layer = mem_rd_data;
      default: begin
        res_next = res;
      end
    endcase
  end

  // transaction, search and result registers
  always_ff @(posedge clk) begin
    res <= res_next;
    case (ctl.op)
      OP_LATCH: begin
        cmd_q <= request.cmd;
        lay_q <= MOD_TABLE[TAG_W*int'(request.layer_id) +: TAG_W];
      end
      OP_UNDO_TAG: begin
        tag_q     <= mem_rd_data;
        scan_addr <= wp_prev;
      end
      OP_SCAN: begin
        scan_addr <= scan_prev;
      end
      default: begin
        scan_addr <= scan_addr;
      end
    endcase
  end

  assign result = res;

endmodule

@@ design/uhrc_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uhrc_ctrl
// Controller state machine: sequences add, undo search and redo through the
// datapath and raises the result strobe.
// ----------------------------------------------------------------------------
module uhrc_ctrl
  import uhrc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  dp_status_t sts,
  output dp_cmd_t    ctl,
  output logic       busy,
  output logic       done
);

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_DISPATCH  = 3'd1;
  localparam logic [2:0] S_ADD_EVICT = 3'd2;
  localparam logic [2:0] S_UNDO_TAG  = 3'd3;
  localparam logic [2:0] S_SCAN      = 3'd4;
  localparam logic [2:0] S_REDO_TAG  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       done_next;

  // next state and datapath operation
  always_comb begin
    state_next = state;
    done_next  = 1'b0;
    ctl.op     = OP_IDLE;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          ctl.op     = OP_LATCH;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (sts.cmd)
          CMD_ADD: begin
            ctl.op = OP_ADD;
            if (sts.full_next) begin
              state_next = S_ADD_EVICT;
            end else begin
              state_next = S_IDLE;
              done_next  = 1'b1;
            end
          end
          CMD_UNDO: begin
            if (sts.empty) begin
              ctl.op     = OP_STATUS_ONE;
              state_next = S_IDLE;
              done_next  = 1'b1;
            end else begin
              ctl.op     = OP_UNDO_START;
              state_next = S_UNDO_TAG;
            end
          end
          CMD_REDO: begin
            if (sts.full_next) begin
              ctl.op     = OP_STATUS_ONE;
              state_next = S_IDLE;
              done_next  = 1'b1;
            end else begin
              ctl.op     = OP_REDO;
              state_next = S_REDO_TAG;
            end
          end
          default: begin
            ctl.op     = OP_STATUS_ONE;
            state_next = S_IDLE;
            done_next  = 1'b1;
          end
        endcase
      end
      S_ADD_EVICT: begin
        ctl.op     = OP_ADD_EVICT;
        state_next = S_IDLE;
        done_next  = 1'b1;
      end
      S_UNDO_TAG: begin
        ctl.op = OP_UNDO_TAG;
        if (sts.undo_base) begin
          state_next = S_IDLE;
          done_next  = 1'b1;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        ctl.op = OP_SCAN;
        if (sts.scan_done) begin
          state_next = S_IDLE;
          done_next  = 1'b1;
        end
      end
      S_REDO_TAG: begin
        ctl.op     = OP_REDO_TAG;
        state_next = S_IDLE;
        done_next  = 1'b1;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state and strobe registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  assign busy = (state != S_IDLE);

endmodule
